// ----- rtl/core/ssu_pkg.sv -----
// ssu_pkg: constants, types, command codes, check table and microcode rom
// for the stack shuffle unit; no dependencies
package ssu_pkg;

    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 64;
    localparam int CELL_BITS    = 32;

    localparam int CMD_W   = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 3;
    localparam int UPC_W   = 5;

    localparam int DLEV_W  = $clog2(DATA_DEPTH + 1);
    localparam int RLEV_W  = $clog2(RETURN_DEPTH + 1);
    localparam int DADDR_W = $clog2(DATA_DEPTH);
    localparam int RADDR_W = $clog2(RETURN_DEPTH);

    typedef logic [CELL_BITS-1:0] t_cell;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 5'd0,
        CMD_DROP     = 5'd1,
        CMD_2DROP    = 5'd2,
        CMD_3DROP    = 5'd3,
        CMD_DUP      = 5'd4,
        CMD_2DUP     = 5'd5,
        CMD_3DUP     = 5'd6,
        CMD_ROT      = 5'd7,
        CMD_MROT     = 5'd8,
        CMD_DUPD     = 5'd9,
        CMD_SWAPD    = 5'd10,
        CMD_NIP      = 5'd11,
        CMD_2NIP     = 5'd12,
        CMD_TUCK     = 5'd13,
        CMD_OVER     = 5'd14,
        CMD_PICK     = 5'd15,
        CMD_SWAP     = 5'd16,
        CMD_TO_RET   = 5'd17,
        CMD_FROM_RET = 5'd18,
        CMD_CLEAR    = 5'd19
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUNDER = 3'd1,
        ST_DOVER  = 3'd2,
        ST_RUNDER = 3'd3,
        ST_ROVER  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_CHECK,
        SQ_RUN,
        SQ_DONE
    } t_seq_state;

    typedef enum logic [2:0] {
        DOP_NOP,
        DOP_PUSH,
        DOP_POP,
        DOP_ROT,
        DOP_MROT,
        DOP_SWAP,
        DOP_SWAPD,
        DOP_CLR
    } t_dop;

    typedef enum logic [2:0] {
        SRC_VAL,
        SRC_T0,
        SRC_T1,
        SRC_T2,
        SRC_RET
    } t_src;

    typedef enum logic [1:0] {
        ROP_NOP,
        ROP_PUSH,
        ROP_POP
    } t_rop;

    typedef struct packed {
        t_dop dop;
        t_src src;
        t_rop rop;
        logic last;
    } t_uword;

    typedef struct packed {
        logic [1:0] need;
        logic [1:0] grow;
        logic       rneed;
        logic       rgrow;
    } t_need;

    localparam logic [UPC_W-1:0] UA_NONE     = 5'd0;
    localparam logic [UPC_W-1:0] UA_PUSH     = 5'd1;
    localparam logic [UPC_W-1:0] UA_DROP     = 5'd2;
    localparam logic [UPC_W-1:0] UA_3DROP    = 5'd3;
    localparam logic [UPC_W-1:0] UA_2DROP    = 5'd5;
    localparam logic [UPC_W-1:0] UA_DUP      = 5'd8;
    localparam logic [UPC_W-1:0] UA_2DUP     = 5'd9;
    localparam logic [UPC_W-1:0] UA_OVER     = 5'd10;
    localparam logic [UPC_W-1:0] UA_3DUP     = 5'd11;
    localparam logic [UPC_W-1:0] UA_PICK     = 5'd13;
    localparam logic [UPC_W-1:0] UA_ROT      = 5'd14;
    localparam logic [UPC_W-1:0] UA_MROT     = 5'd15;
    localparam logic [UPC_W-1:0] UA_2NIP     = 5'd16;
    localparam logic [UPC_W-1:0] UA_DUPD     = 5'd20;
    localparam logic [UPC_W-1:0] UA_SWAPD    = 5'd22;
    localparam logic [UPC_W-1:0] UA_NIP      = 5'd23;
    localparam logic [UPC_W-1:0] UA_TUCK     = 5'd25;
    localparam logic [UPC_W-1:0] UA_SWAP     = 5'd27;
    localparam logic [UPC_W-1:0] UA_TO_RET   = 5'd28;
    localparam logic [UPC_W-1:0] UA_FROM_RET = 5'd30;
    localparam logic [UPC_W-1:0] UA_CLEAR    = 5'd31;

    function automatic t_uword mk(input t_dop d, input t_src s, input t_rop r,
                                  input logic l);
        t_uword w;
        w.dop  = d;
        w.src  = s;
        w.rop  = r;
        w.last = l;
        return w;
    endfunction

    function automatic t_uword urom(input logic [UPC_W-1:0] a);
        t_uword w;
        unique case (a)
            5'd0:  w = mk(DOP_NOP,   SRC_VAL, ROP_NOP,  1'b1);
            5'd1:  w = mk(DOP_PUSH,  SRC_VAL, ROP_NOP,  1'b1);
            5'd2:  w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b1);
            5'd3:  w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b0);
            5'd4:  w = mk(DOP_NOP,   SRC_VAL, ROP_NOP,  1'b0);
            5'd5:  w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b0);
            5'd6:  w = mk(DOP_NOP,   SRC_VAL, ROP_NOP,  1'b0);
            5'd7:  w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b1);
            5'd8:  w = mk(DOP_PUSH,  SRC_T0,  ROP_NOP,  1'b1);
            5'd9:  w = mk(DOP_PUSH,  SRC_T1,  ROP_NOP,  1'b0);
            5'd10: w = mk(DOP_PUSH,  SRC_T1,  ROP_NOP,  1'b1);
            5'd11: w = mk(DOP_PUSH,  SRC_T2,  ROP_NOP,  1'b0);
            5'd12: w = mk(DOP_PUSH,  SRC_T2,  ROP_NOP,  1'b0);
            5'd13: w = mk(DOP_PUSH,  SRC_T2,  ROP_NOP,  1'b1);
            5'd14: w = mk(DOP_ROT,   SRC_VAL, ROP_NOP,  1'b1);
            5'd15: w = mk(DOP_MROT,  SRC_VAL, ROP_NOP,  1'b1);
            5'd16: w = mk(DOP_MROT,  SRC_VAL, ROP_NOP,  1'b0);
            5'd17: w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b0);
            5'd18: w = mk(DOP_NOP,   SRC_VAL, ROP_NOP,  1'b0);
            5'd19: w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b1);
            5'd20: w = mk(DOP_PUSH,  SRC_T1,  ROP_NOP,  1'b0);
            5'd21: w = mk(DOP_SWAP,  SRC_VAL, ROP_NOP,  1'b1);
            5'd22: w = mk(DOP_SWAPD, SRC_VAL, ROP_NOP,  1'b1);
            5'd23: w = mk(DOP_SWAP,  SRC_VAL, ROP_NOP,  1'b0);
            5'd24: w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b1);
            5'd25: w = mk(DOP_SWAP,  SRC_VAL, ROP_NOP,  1'b0);
            5'd26: w = mk(DOP_PUSH,  SRC_T1,  ROP_NOP,  1'b1);
            5'd27: w = mk(DOP_SWAP,  SRC_VAL, ROP_NOP,  1'b1);
            5'd28: w = mk(DOP_NOP,   SRC_VAL, ROP_PUSH, 1'b0);
            5'd29: w = mk(DOP_POP,   SRC_VAL, ROP_NOP,  1'b1);
            5'd30: w = mk(DOP_PUSH,  SRC_RET, ROP_POP,  1'b1);
            5'd31: w = mk(DOP_CLR,   SRC_VAL, ROP_NOP,  1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] uentry(input logic [CMD_W-1:0] c);
        logic [UPC_W-1:0] e;
        unique case (c)
            CMD_PUSH:     e = UA_PUSH;
            CMD_DROP:     e = UA_DROP;
            CMD_2DROP:    e = UA_2DROP;
            CMD_3DROP:    e = UA_3DROP;
            CMD_DUP:      e = UA_DUP;
            CMD_2DUP:     e = UA_2DUP;
            CMD_3DUP:     e = UA_3DUP;
            CMD_ROT:      e = UA_ROT;
            CMD_MROT:     e = UA_MROT;
            CMD_DUPD:     e = UA_DUPD;
            CMD_SWAPD:    e = UA_SWAPD;
            CMD_NIP:      e = UA_NIP;
            CMD_2NIP:     e = UA_2NIP;
            CMD_TUCK:     e = UA_TUCK;
            CMD_OVER:     e = UA_OVER;
            CMD_PICK:     e = UA_PICK;
            CMD_SWAP:     e = UA_SWAP;
            CMD_TO_RET:   e = UA_TO_RET;
            CMD_FROM_RET: e = UA_FROM_RET;
            CMD_CLEAR:    e = UA_CLEAR;
            default:      e = UA_NONE;
        endcase
        return e;
    endfunction

    function automatic t_need cmd_need(input logic [CMD_W-1:0] c);
        t_need n;
        n = '0;
        unique case (c)
            CMD_PUSH:     n.grow = 2'd1;
            CMD_DROP:     n.need = 2'd1;
            CMD_2DROP:    n.need = 2'd2;
            CMD_3DROP:    n.need = 2'd3;
            CMD_DUP: begin
                n.need = 2'd1;
                n.grow = 2'd1;
            end
            CMD_2DUP: begin
                n.need = 2'd2;
                n.grow = 2'd2;
            end
            CMD_3DUP: begin
                n.need = 2'd3;
                n.grow = 2'd3;
            end
            CMD_ROT, CMD_MROT, CMD_SWAPD, CMD_2NIP: n.need = 2'd3;
            CMD_DUPD, CMD_TUCK, CMD_OVER: begin
                n.need = 2'd2;
                n.grow = 2'd1;
            end
            CMD_NIP, CMD_SWAP: n.need = 2'd2;
            CMD_PICK: begin
                n.need = 2'd3;
                n.grow = 2'd1;
            end
            CMD_TO_RET: begin
                n.need  = 2'd1;
                n.rgrow = 1'b1;
            end
            CMD_FROM_RET: begin
                n.rneed = 1'b1;
                n.grow  = 2'd1;
            end
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/core/stack_shuffle_unit.sv -----
// stack_shuffle_unit: data and return stacks driven by a microcode sequencer
// depends on ssu_pkg (types, check table, microcode rom)
//
//   beat     direction  handshake           fields
//   command  in         i_valid / o_stall   i_command, i_push_value
//   result   out        o_valid / i_stall   o_top_cell, o_second_cell,
//                                           o_data_count, o_return_count, o_status
//
// one command at a time: accept, a check state, 0 to 5 microcode steps (none when
// refused), a result state; pops wait a step for the read
// top three data cells live in registers, the rest in a stack memory with one write
// and one registered read per cycle
// synchronous active-low reset empties both stacks; memories are not cleared
// a held result does not block the next command, only its result cycle
module stack_shuffle_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ssu_pkg::CMD_W-1:0]     i_command,
    input  logic [ssu_pkg::VALUE_W-1:0]   i_push_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ssu_pkg::VALUE_W-1:0]   o_top_cell,
    output logic [ssu_pkg::VALUE_W-1:0]   o_second_cell,
    output logic [ssu_pkg::COUNT_W-1:0]   o_data_count,
    output logic [ssu_pkg::COUNT_W-1:0]   o_return_count,
    output logic [ssu_pkg::STAT_W-1:0]    o_status
);
    import ssu_pkg::*;

    t_seq_state         r_state, n_state;
    logic [UPC_W-1:0]   r_upc;
    logic [CMD_W-1:0]   r_cmd;
    t_cell              r_val;
    t_cell              r_t0, r_t1, r_t2;
    t_cell              r_drd, r_rrd;
    logic [DLEV_W-1:0]  r_dlev;
    logic [RLEV_W-1:0]  r_rlev;
    t_status            r_status;

    t_cell              r_dmem [DATA_DEPTH];
    t_cell              r_rmem [RETURN_DEPTH];

    logic                 r_ov;
    logic [VALUE_W-1:0]   r_otop, r_osec;
    logic [COUNT_W-1:0]   r_odc, r_orc;
    t_status              r_ost;

    t_uword             w_uw;
    t_need              w_need;
    t_status            w_status;
    t_cell              w_src;
    logic               w_accept;
    logic               w_out_free;
    logic               w_run;
    logic [DADDR_W-1:0] w_spill_addr, w_fill_addr;
    logic [RADDR_W-1:0] w_rwr_addr, w_rrd_addr;

    assign w_uw   = urom(r_upc);
    assign w_need = cmd_need(r_cmd);
    assign w_run  = (r_state == SQ_RUN);

    // checks in order of priority
    always_comb begin
        priority if (r_dlev < DLEV_W'(w_need.need))
            w_status = ST_DUNDER;
        else if (({1'b0, r_dlev} + (DLEV_W+1)'(w_need.grow)) > (DLEV_W+1)'(DATA_DEPTH))
            w_status = ST_DOVER;
        else if (r_rlev < RLEV_W'(w_need.rneed))
            w_status = ST_RUNDER;
        else if (({1'b0, r_rlev} + (RLEV_W+1)'(w_need.rgrow)) > (RLEV_W+1)'(RETURN_DEPTH))
            w_status = ST_ROVER;
        else
            w_status = ST_OK;
    end

    always_comb begin
        unique case (w_uw.src)
            SRC_VAL: w_src = r_val;
            SRC_T0:  w_src = r_t0;
            SRC_T1:  w_src = r_t1;
            SRC_T2:  w_src = r_t2;
            SRC_RET: w_src = r_rrd;
            default: w_src = r_val;
        endcase
    end

    assign w_spill_addr = DADDR_W'(r_dlev - DLEV_W'(3));
    assign w_fill_addr  = DADDR_W'(r_dlev - DLEV_W'(4));
    assign w_rwr_addr   = RADDR_W'(r_rlev);
    assign w_rrd_addr   = RADDR_W'(r_rlev - RLEV_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE:  if (i_valid) n_state = SQ_CHECK;
            SQ_CHECK: n_state = (w_status != ST_OK) ? SQ_DONE : SQ_RUN;
            SQ_RUN:   if (w_uw.last) n_state = SQ_DONE;
            SQ_DONE:  if (w_out_free) n_state = SQ_IDLE;
            default:  n_state = SQ_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_stall    = (r_state != SQ_IDLE);
        w_accept   = i_valid && (r_state == SQ_IDLE);
        w_out_free = !r_ov || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_val <= CELL_BITS'(i_push_value);
        end
        if (!i_rst_n) begin
            r_upc <= UA_NONE;
        end else if (r_state == SQ_CHECK) begin
            r_upc    <= uentry(r_cmd);
            r_status <= w_status;
        end else if (w_run) begin
            r_upc <= r_upc + UPC_W'(1);
        end
    end

    // stack levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlev <= '0;
            r_rlev <= '0;
        end else if (r_state == SQ_CHECK) begin
            if (w_status == ST_DUNDER || w_status == ST_DOVER) begin
                r_dlev <= '0;
            end else if (w_status == ST_RUNDER || w_status == ST_ROVER) begin
                r_rlev <= '0;
            end
        end else if (w_run) begin
            unique case (w_uw.dop)
                DOP_PUSH: r_dlev <= r_dlev + DLEV_W'(1);
                DOP_POP:  r_dlev <= r_dlev - DLEV_W'(1);
                DOP_CLR: begin
                    r_dlev <= '0;
                    r_rlev <= '0;
                end
                default: ;
            endcase
            unique case (w_uw.rop)
                ROP_PUSH: r_rlev <= r_rlev + RLEV_W'(1);
                ROP_POP:  r_rlev <= r_rlev - RLEV_W'(1);
                default:  ;
            endcase
        end
    end

    // top-of-stack registers
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            unique case (w_uw.dop)
                DOP_PUSH: begin
                    r_t0 <= w_src;
                    r_t1 <= r_t0;
                    r_t2 <= r_t1;
                end
                DOP_POP: begin
                    r_t0 <= r_t1;
                    r_t1 <= r_t2;
                    r_t2 <= r_drd;
                end
                DOP_ROT: begin
                    r_t2 <= r_t1;
                    r_t1 <= r_t0;
                    r_t0 <= r_t2;
                end
                DOP_MROT: begin
                    r_t2 <= r_t0;
                    r_t1 <= r_t2;
                    r_t0 <= r_t1;
                end
                DOP_SWAP: begin
                    r_t0 <= r_t1;
                    r_t1 <= r_t0;
                end
                DOP_SWAPD: begin
                    r_t2 <= r_t1;
                    r_t1 <= r_t2;
                end
                default: ;
            endcase
        end
    end

    // data stack memory: spill on push, refill read for the next pop
    always_ff @(posedge i_clk) begin
        if (w_run && w_uw.dop == DOP_PUSH && r_dlev >= DLEV_W'(3)) begin
            r_dmem[w_spill_addr] <= r_t2;
        end
        r_drd <= r_dmem[w_fill_addr];
    end

    // return stack memory
    always_ff @(posedge i_clk) begin
        if (w_run && w_uw.rop == ROP_PUSH) begin
            r_rmem[w_rwr_addr] <= r_t0;
        end
        r_rrd <= r_rmem[w_rrd_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == SQ_DONE && w_out_free) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SQ_DONE && w_out_free) begin
            r_otop <= (r_dlev >= DLEV_W'(1)) ? VALUE_W'(r_t0) : '0;
            r_osec <= (r_dlev >= DLEV_W'(2)) ? VALUE_W'(r_t1) : '0;
            r_odc  <= COUNT_W'(r_dlev);
            r_orc  <= COUNT_W'(r_rlev);
            r_ost  <= r_status;
        end
    end

    assign o_valid        = r_ov;
    assign o_top_cell     = r_otop;
    assign o_second_cell  = r_osec;
    assign o_data_count   = r_odc;
    assign o_return_count = r_orc;
    assign o_status       = r_ost;

endmodule

// ----- rtl/core/ssu_check.sv -----
// ssu_check: port-level assertions for the stack shuffle unit, bound to the top
// depends on ssu_pkg and stack_shuffle_unit
module ssu_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [ssu_pkg::VALUE_W-1:0]   o_top_cell,
    input logic [ssu_pkg::VALUE_W-1:0]   o_second_cell,
    input logic [ssu_pkg::COUNT_W-1:0]   o_data_count,
    input logic [ssu_pkg::COUNT_W-1:0]   o_return_count,
    input logic [ssu_pkg::STAT_W-1:0]    o_status
);
    import ssu_pkg::*;

    // held result beat keeps its top cell and status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_top_cell) && $stable(o_status))
        else $error("result beat changed while stalled");

    // one command in flight
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("command accepted while busy");

    // data error empties the data stack
    a_derr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DUNDER || o_status == ST_DOVER) |-> o_data_count == '0)
        else $error("data error with non-empty data stack");

    // return error empties the return stack
    a_rerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_RUNDER || o_status == ST_ROVER) |-> o_return_count == '0)
        else $error("return error with non-empty return stack");

    // shallow stack shows zero below the top
    a_shallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_count < COUNT_W'(2) |-> o_second_cell == '0)
        else $error("second cell not zero on shallow stack");

endmodule

bind stack_shuffle_unit ssu_check u_ssu_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_top_cell     (o_top_cell),
    .o_second_cell  (o_second_cell),
    .o_data_count   (o_data_count),
    .o_return_count (o_return_count),
    .o_status       (o_status)
);
